// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pbwft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbwft_pkg;

    localparam int LENGTH_BITS       = 32;
    localparam int VARINT_MAX_BYTES  = 10;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
    localparam logic [2:0] ERR_WIRE_TYPE = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;

    typedef enum logic [4:0] {
        PH_TAG     = 5'b00001,
        PH_VARINT  = 5'b00010,
        PH_FIXED   = 5'b00100,
        PH_LENGTH  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t                   phase;
        logic [63:0]              acc;
        logic [3:0]               byte_count;
        logic [31:0]              field;
        logic [2:0]               wtype;
        logic [LENGTH_BITS-1:0]   remaining;
        logic                     dropping;
    } state_t;

    localparam state_t ST_RESET = '{
        phase:      PH_TAG,
        acc:        64'd0,
        byte_count: 4'd0,
        field:      32'd0,
        wtype:      3'd0,
        remaining:  LENGTH_BITS'(0),
        dropping:   1'b0
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic        valid;
        in_word_t    word;
    } in_hold_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic [63:0] zigzag;
        logic [2:0]  error_code;
        logic        end_of_buffer;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/pbwft_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbwft_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pbwft_pkg::in_word_t in_word,
    input  wire logic               take,
    output pbwft_pkg::in_hold_t     hold
);
    import pbwft_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.word  = word_reg;

endmodule

`default_nettype wire

// ----- rtl/pbwft_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbwft_decode (
    input  wire pbwft_pkg::state_t   st,
    input  wire pbwft_pkg::in_word_t word,
    output pbwft_pkg::state_t        st_next,
    output pbwft_pkg::result_t       res,
    output logic                     res_valid
);
    import pbwft_pkg::*;

    logic [7:0]  data;
    logic        last;
    logic [6:0]  prod7;
    logic [5:0]  sh7;
    logic [5:0]  sh8;
    logic [63:0] acc_var;
    logic [63:0] acc_fix;
    logic [3:0]  cnt_inc;
    logic [3:0]  fix_size;
    logic        v_more;
    logic        too_long;
    logic        v_fail;
    logic [2:0]  v_code;
    logic [31:0] tag_field;
    logic [2:0]  tag_wt;
    logic        too_big;
    logic        fail;
    logic [2:0]  fcode;
    logic [31:0] ffield;
    logic [2:0]  fwt;

    assign data      = word.data;
    assign last      = word.last;
    assign prod7     = 7'(st.byte_count) * 7'd7;
    assign sh7       = prod7[5:0];
    assign sh8       = {st.byte_count[2:0], 3'b000};
    assign acc_var   = st.acc | (64'(data[6:0]) << sh7);
    assign acc_fix   = st.acc | (64'(data) << sh8);
    assign cnt_inc   = st.byte_count + 4'd1;
    assign fix_size  = (st.wtype == WT_FIXED64) ? 4'd8 : 4'd4;
    assign v_more    = data[7];
    assign too_long  = cnt_inc >= 4'(VARINT_MAX_BYTES);
    assign v_fail    = v_more && (too_long || last);
    assign v_code    = (too_long && !last) ? ERR_TOO_LONG : ERR_TRUNCATED;
    assign tag_field = acc_var[34:3];
    assign tag_wt    = acc_var[2:0];
    assign too_big   = (acc_var >> LENGTH_BITS) != 64'd0;

    always_comb
    begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;
        res.end_of_buffer = last;
        fail      = 1'b0;
        fcode     = ERR_TRUNCATED;
        ffield    = st.field;
        fwt       = st.wtype;

        if (st.dropping)
        begin
            if (last)
            begin
                st_next = ST_RESET;
            end
        end
        else
        begin
            unique case (st.phase)
                PH_TAG:
                begin
                    ffield = 32'd0;
                    fwt    = 3'd0;
                    if (!v_more)
                    begin
                        st_next.acc        = 64'd0;
                        st_next.byte_count = 4'd0;
                        st_next.field      = tag_field;
                        st_next.wtype      = tag_wt;
                        unique case (tag_wt)
                            WT_VARINT:  st_next.phase = PH_VARINT;
                            WT_FIXED64: st_next.phase = PH_FIXED;
                            WT_FIXED32: st_next.phase = PH_FIXED;
                            WT_LEN:     st_next.phase = PH_LENGTH;
                            default:
                            begin
                                fail  = 1'b1;
                                fcode = ERR_WIRE_TYPE;
                            end
                        endcase
                        if (!fail && last)
                        begin
                            fail   = 1'b1;
                            fcode  = ERR_TRUNCATED;
                            ffield = tag_field;
                            fwt    = tag_wt;
                        end
                    end
                    else if (v_fail)
                    begin
                        fail  = 1'b1;
                        fcode = v_code;
                    end
                    else
                    begin
                        st_next.acc        = acc_var;
                        st_next.byte_count = cnt_inc;
                    end
                end
                PH_VARINT:
                begin
                    if (!v_more)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SCALAR;
                        res.field_number = st.field;
                        res.wtype        = st.wtype;
                        res.value        = acc_var;
                        res.zigzag       = (acc_var >> 1) ^ {64{acc_var[0]}};
                        st_next          = ST_RESET;
                    end
                    else if (v_fail)
                    begin
                        fail  = 1'b1;
                        fcode = v_code;
                    end
                    else
                    begin
                        st_next.acc        = acc_var;
                        st_next.byte_count = cnt_inc;
                    end
                end
                PH_FIXED:
                begin
                    if (cnt_inc < fix_size)
                    begin
                        if (last)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            st_next.acc        = acc_fix;
                            st_next.byte_count = cnt_inc;
                        end
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SCALAR;
                        res.field_number = st.field;
                        res.wtype        = st.wtype;
                        res.value        = acc_fix;
                        res.zigzag       = (fix_size == 4'd4)
                                           ? {{32{acc_fix[31]}}, acc_fix[31:0]}
                                           : acc_fix;
                        st_next          = ST_RESET;
                    end
                end
                PH_LENGTH:
                begin
                    if (!v_more)
                    begin
                        if (too_big)
                        begin
                            fail  = 1'b1;
                            fcode = ERR_LENGTH;
                        end
                        else if ((acc_var != 64'd0) && last)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_HEADER;
                            res.field_number = st.field;
                            res.wtype        = st.wtype;
                            res.value        = acc_var;
                            res.zigzag       = acc_var;
                            if (acc_var == 64'd0)
                            begin
                                st_next = ST_RESET;
                            end
                            else
                            begin
                                st_next.phase      = PH_PAYLOAD;
                                st_next.acc        = 64'd0;
                                st_next.byte_count = 4'd0;
                                st_next.remaining  = acc_var[LENGTH_BITS-1:0];
                            end
                        end
                    end
                    else if (v_fail)
                    begin
                        fail  = 1'b1;
                        fcode = v_code;
                    end
                    else
                    begin
                        st_next.acc        = acc_var;
                        st_next.byte_count = cnt_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    if ((st.remaining > LENGTH_BITS'(1)) && last)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.field_number = st.field;
                        res.wtype        = st.wtype;
                        res.value        = 64'(data);
                        res.zigzag       = 64'(data);
                        if ((st.remaining == LENGTH_BITS'(1)) || last)
                        begin
                            st_next = ST_RESET;
                        end
                        else
                        begin
                            st_next.remaining = st.remaining - LENGTH_BITS'(1);
                        end
                    end
                end
                default:
                begin
                    st_next = ST_RESET;
                end
            endcase

            if (fail)
            begin
                res_valid          = 1'b1;
                res                = '0;
                res.kind           = KIND_ERROR;
                res.field_number   = ffield;
                res.wtype          = fwt;
                res.error_code     = fcode;
                res.end_of_buffer  = last;
                st_next            = ST_RESET;
                st_next.dropping   = !last;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/protobuf_wire_field_tokenizer_unit.sv -----
// Protocol buffers wire-format tokenizer: one encoded byte per word, one
// word per cycle sustained while results are not held back by out_ready.
// Each byte passes an input register, one decode step against the running
// field state, and a result register, and at most one result follows from
// a byte. Varint, fixed32/fixed64 and length-delimited fields are split
// into scalar, header and payload results; after an error the bytes up to
// the buffer's last byte are consumed without results.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_wire_field_tokenizer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_of_buffer,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              kind,
    output logic [31:0]             field_number,
    output logic [2:0]              wtype,
    output logic [63:0]             value,
    output logic signed [63:0]      zigzag_value,
    output logic [2:0]              error_code,
    output logic                    end_of_buffer
);
    import pbwft_pkg::*;

    in_word_t in_word;
    in_hold_t hold;
    logic     take;
    state_t   state_reg;
    state_t   state_next;
    result_t  res;
    logic     res_valid;
    result_t  result_reg;
    logic     out_valid_reg;
    logic     out_valid_next;

    assign in_word.data = data_byte;
    assign in_word.last = last_of_buffer;

    pbwft_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .take     (take),
        .hold     (hold)
    );

    pbwft_decode u_decode (
        .st        (state_reg),
        .word      (hold.word),
        .st_next   (state_next),
        .res       (res),
        .res_valid (res_valid)
    );

    // advance when the byte makes no result, or the result slot is free or drains this cycle
    assign take = hold.valid && (!res_valid || !out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = result_reg.kind;
    assign field_number  = result_reg.field_number;
    assign wtype         = result_reg.wtype;
    assign value         = result_reg.value;
    assign zigzag_value  = $signed(result_reg.zigzag);
    assign error_code    = result_reg.error_code;
    assign end_of_buffer = result_reg.end_of_buffer;

endmodule

`default_nettype wire

// ----- rtl/pbwft_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pbwft_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [31:0]        field_number,
    input  wire logic [2:0]         wtype,
    input  wire logic [63:0]        value,
    input  wire logic signed [63:0] zigzag_value,
    input  wire logic [2:0]         error_code,
    input  wire logic               end_of_buffer
);
    import pbwft_pkg::*;

    logic         err_word;
    logic         err_ok;
    logic         hdr_word;
    logic         hdr_ok;
    logic         pay_word;
    logic         pay_ok;
    logic         stall;
    logic [168:0] out_bits;

    assign err_word = out_valid && (kind == KIND_ERROR);
    assign err_ok   = (value == 64'd0) && (zigzag_value == 64'sd0)
                      && (error_code != ERR_NONE);
    assign hdr_word = out_valid && (kind == KIND_HEADER);
    assign hdr_ok   = (wtype == WT_LEN) && ((value >> LENGTH_BITS) == 64'd0)
                      && (error_code == ERR_NONE);
    assign pay_word = out_valid && (kind == KIND_PAYLOAD);
    assign pay_ok   = (value[63:8] == 56'd0) && (zigzag_value == $signed(value))
                      && (wtype == WT_LEN);
    assign stall    = out_valid && !out_ready;
    assign out_bits = {kind, field_number, wtype, value, zigzag_value, error_code,
                       end_of_buffer};

    `ASSERT_CLK(a_error_fields, err_word |-> err_ok, "error word carries a value or no code")

    `ASSERT_CLK(a_header_shape, hdr_word |-> hdr_ok, "bad length header")

    `ASSERT_CLK(a_payload_shape, pay_word |-> pay_ok, "bad payload word")

    `ASSERT_CLK(a_out_hold, stall |=> out_valid && $stable(out_bits), "stalled result changed")

    `ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind protobuf_wire_field_tokenizer_unit pbwft_checker u_checker (.*);

`default_nettype wire
